FILE: hw/rtl/boxg_pkg.sv
// Shared constants, types and codes for the box occupancy grid.
// No dependencies; every other file in hw/rtl depends on this package.
`default_nettype none
package boxg_pkg;

  localparam int MAX_DIM  = 16;
  localparam int COORD_W  = $clog2(MAX_DIM);
  localparam int DIM_W    = COORD_W + 1;
  localparam int END_W    = DIM_W + 1;
  localparam int ROW_AW   = 2 * COORD_W;
  localparam int ROWS     = MAX_DIM * MAX_DIM;

  localparam int CMD_W      = 2;
  localparam int START_W    = 4;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_CHECK = 2'd0;
  localparam cmd_t CMD_MARK  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DIM_X  = 2'd0;
  localparam cfg_idx_t REG_DIM_Y  = 2'd1;
  localparam cfg_idx_t REG_DIM_Z  = 2'd2;
  localparam cfg_idx_t REG_MARGIN = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] dim_x;
    logic [CFG_DATA_W-1:0] dim_y;
    logic [CFG_DATA_W-1:0] dim_z;
    logic                  margin;
  } grid_cfg_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic               clr;
    logic [ROW_AW-1:0]  addr;
    logic [MAX_DIM-1:0] wr_data;
  } store_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/boxg_if.sv
// Request and result channel interfaces for the box occupancy grid.
// Depends on boxg_pkg for field widths.
`default_nettype none
interface boxg_in_if;
  logic                             valid;
  logic                             ready;
  logic [boxg_pkg::CMD_W-1:0]       cmd;
  logic [boxg_pkg::START_W-1:0]     start_x;
  logic [boxg_pkg::START_W-1:0]     start_y;
  logic [boxg_pkg::START_W-1:0]     start_z;
  logic [boxg_pkg::SIZE_W-1:0]      size_x;
  logic [boxg_pkg::SIZE_W-1:0]      size_y;
  logic [boxg_pkg::SIZE_W-1:0]      size_z;

  modport source (output valid, cmd, start_x, start_y, start_z, size_x, size_y, size_z,
                  input ready);
  modport sink (input valid, cmd, start_x, start_y, start_z, size_x, size_y, size_z,
                output ready);
endinterface

interface boxg_out_if;
  logic valid;
  logic ready;
  logic box_free;

  modport source (output valid, box_free, input ready);
  modport sink (input valid, box_free, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/boxg_store.sv
// Occupancy store: one row of X cells per (Y,Z) pair, synchronous read.
// Row valid flags let a clear free every row at once. Depends on boxg_pkg.
`default_nettype none
module boxg_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire boxg_pkg::store_req_t      req,
  output logic [boxg_pkg::MAX_DIM-1:0]   rd_data
);
  import boxg_pkg::*;

  logic [MAX_DIM-1:0] mem [ROWS];
  logic [ROWS-1:0]    row_vld_r;
  logic [MAX_DIM-1:0] rd_word_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.clr) begin
        row_vld_r <= '0;
      end else if (req.wr_en) begin
        row_vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/boxg_seq.sv
// Command sequencer: bounds setup, row-by-row read (read-modify-write for mark), result register.
// Depends on boxg_pkg and boxg_if; drives the store request of boxg_store.
`default_nettype none
module boxg_seq (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire boxg_pkg::grid_cfg_t      cfg,
  boxg_in_if.sink                       in_req,
  boxg_out_if.source                    out_res,
  output boxg_pkg::store_req_t          st_req,
  input  wire logic [boxg_pkg::MAX_DIM-1:0] st_rd_data
);
  import boxg_pkg::*;

  seq_state_t state_r, state_nxt;

  cmd_t               cmd_r, cmd_nxt;
  logic [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [END_W-1:0]   ex_r, ex_nxt, ey_r, ey_nxt, ez_r, ez_nxt;
  logic [DIM_W-1:0]   yhi_r, yhi_nxt, zhi_r, zhi_nxt;
  logic [COORD_W-1:0] y_r, y_nxt, z_r, z_nxt;
  logic [MAX_DIM-1:0] mask_r, mask_nxt;
  logic               free_r, free_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free_r, out_free_nxt;

  logic               accept;
  logic               out_slot;
  logic [DIM_W-1:0]   dx_c, dy_c, dz_c;
  logic [END_W-1:0]   xhi, yhi_s, zhi_s;
  logic [COORD_W-1:0] xlo;
  logic [MAX_DIM-1:0] mask_s;
  logic               empty_s;
  logic [DIM_W-1:0]   z_inc, y_inc;
  logic               z_last, y_last, hit;

  assign accept   = in_req.valid && in_req.ready;
  assign out_slot = !out_valid_r || out_res.ready;

  assign dx_c = (cfg.dim_x > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.dim_x;
  assign dy_c = (cfg.dim_y > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.dim_y;
  assign dz_c = (cfg.dim_z > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.dim_z;

  assign xhi   = (ex_r < END_W'(dx_c)) ? ex_r : END_W'(dx_c);
  assign yhi_s = (ey_r < END_W'(dy_c)) ? ey_r : END_W'(dy_c);
  assign zhi_s = (ez_r < END_W'(dz_c)) ? ez_r : END_W'(dz_c);
  assign xlo   = (cmd_r == CMD_CHECK && cfg.margin && sx_r != '0) ? sx_r - 1'b1 : sx_r;

  always_comb begin
    for (int i = 0; i < MAX_DIM; i++) begin
      mask_s[i] = (END_W'(i) >= END_W'(xlo)) && (END_W'(i) < xhi);
    end
  end

  assign empty_s = (mask_s == '0) || (END_W'(sy_r) >= yhi_s) || (END_W'(sz_r) >= zhi_s);

  assign z_inc  = DIM_W'(z_r) + 1'b1;
  assign y_inc  = DIM_W'(y_r) + 1'b1;
  assign z_last = z_inc >= zhi_r;
  assign y_last = y_inc >= yhi_r;
  assign hit    = |(st_rd_data & mask_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        if (cmd_r == CMD_CHECK || cmd_r == CMD_MARK) begin
          state_nxt = empty_s ? S_DONE : S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_WAIT;
      S_WAIT: begin
        if ((cmd_r == CMD_CHECK && hit) || (z_last && y_last)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (out_slot) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready   = (state_r == S_IDLE);
    st_req         = '0;
    st_req.addr    = {z_r, y_r};
    st_req.wr_data = st_rd_data | mask_r;
    case (state_r)
      S_SETUP: st_req.clr   = (cmd_r == CMD_CLEAR);
      S_READ:  st_req.rd_en = 1'b1;
      S_WAIT:  st_req.wr_en = (cmd_r == CMD_MARK);
      default: st_req.rd_en = 1'b0;
    endcase
  end

  always_comb begin
    cmd_nxt  = cmd_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sz_nxt   = sz_r;
    ex_nxt   = ex_r;
    ey_nxt   = ey_r;
    ez_nxt   = ez_r;
    yhi_nxt  = yhi_r;
    zhi_nxt  = zhi_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    mask_nxt = mask_r;
    free_nxt = free_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_free_nxt  = out_free_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_req.cmd;
          sx_nxt  = COORD_W'(in_req.start_x);
          sy_nxt  = COORD_W'(in_req.start_y);
          sz_nxt  = COORD_W'(in_req.start_z);
          ex_nxt  = END_W'(in_req.start_x) + END_W'(in_req.size_x);
          ey_nxt  = END_W'(in_req.start_y) + END_W'(in_req.size_y);
          ez_nxt  = END_W'(in_req.start_z) + END_W'(in_req.size_z);
        end
      end
      S_SETUP: begin
        mask_nxt = mask_s;
        yhi_nxt  = DIM_W'(yhi_s);
        zhi_nxt  = DIM_W'(zhi_s);
        y_nxt    = sy_r;
        z_nxt    = sz_r;
        free_nxt = 1'b1;
      end
      S_WAIT: begin
        if (cmd_r == CMD_CHECK && hit) free_nxt = 1'b0;
        if (z_last) begin
          z_nxt = sz_r;
          y_nxt = y_inc[COORD_W-1:0];
        end else begin
          z_nxt = z_inc[COORD_W-1:0];
        end
      end
      S_DONE: begin
        if (out_slot) begin
          out_valid_nxt = 1'b1;
          out_free_nxt  = free_r;
        end
      end
      default: free_nxt = free_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    sz_r       <= sz_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    ez_r       <= ez_nxt;
    yhi_r      <= yhi_nxt;
    zhi_r      <= zhi_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    mask_r     <= mask_nxt;
    free_r     <= free_nxt;
    out_free_r <= out_free_nxt;
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.box_free = out_free_r;

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SETUP)
    else $error("accepted request did not enter setup");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.rd_en |=> state_r == S_WAIT)
    else $error("store read not followed by data cycle");

  a_write_mark: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.wr_en |-> cmd_r == CMD_MARK && $past(st_req.rd_en))
    else $error("store write outside a mark read-modify-write");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.clr |=> state_r == S_DONE)
    else $error("clear did not complete in one cycle");

endmodule
`default_nettype wire

FILE: hw/rtl/box_occupancy_grid.sv
// Box occupancy grid top level: configuration registers, sequencer and store.
// A check/mark walks its rows (Y,Z pairs), up to 256, through S_READ and then S_WAIT per row;
// a check stops at the first occupied row. A clear goes from S_SETUP straight to S_DONE.
// The next request is taken only after the last one is done, but it is taken while a result waits.
// Reset: dimensions 16, margin 1, all rows flagged free at once; no clearing sweep.
// Depends on boxg_pkg, boxg_if, boxg_store and boxg_seq.
`default_nettype none
module box_occupancy_grid (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  boxg_in_if.sink                             in_req,
  boxg_out_if.source                          out_res,
  input  wire logic                           cfg_we,
  input  wire logic [boxg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [boxg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import boxg_pkg::*;

  grid_cfg_t          cfg_r;
  store_req_t         st_req;
  logic [MAX_DIM-1:0] st_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x  <= CFG_DATA_W'(16);
      cfg_r.dim_y  <= CFG_DATA_W'(16);
      cfg_r.dim_z  <= CFG_DATA_W'(16);
      cfg_r.margin <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIM_X:  cfg_r.dim_x  <= cfg_wdata;
        REG_DIM_Y:  cfg_r.dim_y  <= cfg_wdata;
        REG_DIM_Z:  cfg_r.dim_z  <= cfg_wdata;
        REG_MARGIN: cfg_r.margin <= cfg_wdata[0];
        default:    cfg_r.margin <= cfg_r.margin;
      endcase
    end
  end

  boxg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_req     (in_req),
    .out_res    (out_res),
    .st_req     (st_req),
    .st_rd_data (st_rd_data)
  );

  boxg_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (st_rd_data)
  );

endmodule
`default_nettype wire
